// ===== sv/fmm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fmm_pkg
// Shared fixed constants of the grid fast marching block.
// ----------------------------------------------------------------------------
package fmm_pkg;

    // operation codes carried on s_tuser
    localparam logic [2:0] FN_CLEAR = 3'd0;
    localparam logic [2:0] FN_COST  = 3'd1;
    localparam logic [2:0] FN_SEED  = 3'd2;
    localparam logic [2:0] FN_RUN   = 3'd3;
    localparam logic [2:0] FN_READ  = 3'd4;

    // register byte addresses
    localparam logic [2:0] ADDR_GRID_WIDTH  = 3'd0;
    localparam logic [2:0] ADDR_GRID_HEIGHT = 3'd4;

    localparam int DIM_W    = 11;  // holds any grid extent up to 1024
    localparam int CFG_W    = 7;
    localparam int COORD_W  = 6;   // row/col fields of the input word
    localparam int COST_W   = 16;
    localparam int MUL_W    = 17;  // multiplier operand width
    localparam int SQ_OUT_W = 17;
    localparam int SQ_IN_W  = 2 * SQ_OUT_W;

    // neighbor directions in visiting order
    localparam logic [1:0] DIR_LEFT  = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_UP    = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;

endpackage
`default_nettype wire

// ===== sv/fmm_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fmm_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== sv/fmm_sqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fmm_sqrt
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module fmm_sqrt (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [fmm_pkg::SQ_IN_W-1:0]  radicand,
    output logic                              done,
    output logic      [fmm_pkg::SQ_OUT_W-1:0] root
);
    import fmm_pkg::*;

    localparam int REM_W = SQ_OUT_W + 3;
    localparam int CNT_W = $clog2(SQ_OUT_W + 1);

    logic [SQ_IN_W-1:0]  rad_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [SQ_OUT_W-1:0] root_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg;
    logic                done_reg;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             fits;

    assign rem_sh = {rem_reg[REM_W-3:0], rad_reg[SQ_IN_W-1 -: 2]};
    assign trial  = REM_W'({root_reg, 2'b01});
    assign fits   = rem_sh >= trial;
    assign done   = done_reg;
    assign root   = root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rad_reg  <= radicand;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rad_reg  <= {rad_reg[SQ_IN_W-3:0], 2'b00};
                rem_reg  <= fits ? rem_sh - trial : rem_sh;
                root_reg <= {root_reg[SQ_OUT_W-2:0], fits};
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SQ_OUT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== sv/grid_fast_marching_distance.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// grid_fast_marching_distance
// Fast marching eikonal solver on a 4-connected grid with a binary min-heap.
// ----------------------------------------------------------------------------
// A clear rewrites all 2^(row bits + col bits) field entries (4096 by default).
// A run's pace is set by the field reads, one entry at a time, and by the
//   bit-serial square root that a fresh neighbor may need.
// One word at a time: s_tready is high only while idle with no result pending.
// Reset: async active low; afterwards a clearing sweep of the field memory
//   runs over all its entries before the first word is taken.
// ----------------------------------------------------------------------------
module grid_fast_marching_distance #(
    parameter int MAX_ROWS  = 64,
    parameter int MAX_COLS  = 64,
    parameter int DIST_BITS = 24
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // input word
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [31:0]            s_tdata,  // row[5:0], col[11:6], cost[27:12]
    input  wire logic [2:0]             s_tuser,  // func[2:0]
    // result word
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // distance[DIST_BITS-1:0], reached, done_res, zero fill
    output logic [((DIST_BITS+9)/8)*8-1:0] m_tdata,
    // register port
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [2:0]             paddr,
    input  wire logic [31:0]            pwdata,
    output logic      [31:0]            prdata,
    output logic                        pready
);
    import fmm_pkg::*;

    localparam int OW    = ((DIST_BITS + 9) / 8) * 8;
    localparam int RB    = $clog2(MAX_ROWS);
    localparam int CB    = $clog2(MAX_COLS);
    localparam int AB    = RB + CB;             // field memory address
    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int HB    = $clog2(CELLS);       // heap index
    localparam int KW    = DIST_BITS + AB;      // heap key: {dist, row, col}
    localparam int FW    = DIST_BITS + 1;       // field entry: {marked, dist}
    localparam logic [DIST_BITS-1:0] INF  = '1;
    localparam logic [DIST_BITS-1:0] MAXF = INF - 1'b1;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_SEED, S_READ,
        S_PUSH, S_UP, S_UP_CMP,
        S_POP, S_POP_TOP, S_POP_LAST, S_DN, S_DN_L, S_DN_R, S_DN_MV, S_POP_DONE,
        S_NB, S_NB_CHK, S_RD, S_RD_USE, S_COST, S_SOLVE, S_MUL_W, S_MUL_D,
        S_DEC, S_SQ, S_STORE
    } state_t;

    state_t state_reg;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]     gw_reg, gh_reg;
    logic [AB-1:0]        clr_cnt_reg;
    logic                 clr_resp_reg;
    logic [RB-1:0]        in_row_reg;
    logic [CB-1:0]        in_col_reg;
    logic [HB:0]          heap_cnt_reg;
    logic [HB-1:0]        hidx_reg, cidx_reg;
    logic [KW-1:0]        pkey_reg, top_reg, hval_reg, child_reg;
    logic                 push_run_reg;
    logic [RB-1:0]        pr_reg, qr_reg;
    logic [CB-1:0]        pc_reg, qc_reg;
    logic [2:0]           k_reg;
    logic [1:0]           j_reg;
    logic                 rd_inv_reg;
    logic [DIST_BITS-1:0] dx_reg, dy_reg, nd_reg;
    logic [COST_W-1:0]    w_reg;
    logic [MUL_W-1:0]     ma_reg;
    logic [SQ_IN_W-1:0]   w2_reg, d2_reg;
    logic                 ovalid_reg, oreached_reg, odone_reg;
    logic [DIST_BITS-1:0] odist_reg;

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    logic              fld_we;
    logic [AB-1:0]     fld_waddr, fld_raddr;
    logic [FW-1:0]     fld_wdata, fld_rdata;
    logic              cst_we;
    logic [AB-1:0]     cst_addr_in, cst_raddr;
    logic [COST_W-1:0] cst_rdata;
    logic              hp_we;
    logic [HB-1:0]     hp_waddr, hp_raddr;
    logic [KW-1:0]     hp_wdata, hp_rdata;

    fmm_ram #(.WIDTH(FW), .DEPTH(1 << AB)) u_field (
        .clk(clk), .we(fld_we), .waddr(fld_waddr), .wdata(fld_wdata),
        .raddr(fld_raddr), .rdata(fld_rdata)
    );

    fmm_ram #(.WIDTH(COST_W), .DEPTH(1 << AB)) u_cost (
        .clk(clk), .we(cst_we), .waddr(cst_addr_in), .wdata(s_tdata[27:12]),
        .raddr(cst_raddr), .rdata(cst_rdata)
    );

    fmm_ram #(.WIDTH(KW), .DEPTH(CELLS)) u_heap (
        .clk(clk), .we(hp_we), .waddr(hp_waddr), .wdata(hp_wdata),
        .raddr(hp_raddr), .rdata(hp_rdata)
    );

    // ------------------------------------------------------------------
    // Grid extents in use: zero acts as one, clamp to the maximum
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] gw_eff, gh_eff;

    always_comb
    begin
        gw_eff = DIM_W'(gw_reg);
        if (gw_reg == '0)
            gw_eff = DIM_W'(1);
        else if (DIM_W'(gw_reg) > DIM_W'(MAX_COLS))
            gw_eff = DIM_W'(MAX_COLS);
        gh_eff = DIM_W'(gh_reg);
        if (gh_reg == '0)
            gh_eff = DIM_W'(1);
        else if (DIM_W'(gh_reg) > DIM_W'(MAX_ROWS))
            gh_eff = DIM_W'(MAX_ROWS);
    end

    // input word fields
    logic [2:0]         in_func;
    logic [COORD_W-1:0] in_row, in_col;
    logic               in_inside;
    logic               accept;

    assign in_func     = s_tuser;
    assign in_row      = s_tdata[5:0];
    assign in_col      = s_tdata[11:6];
    assign in_inside   = (DIM_W'(in_row) < gh_eff) && (DIM_W'(in_col) < gw_eff);
    assign s_tready    = (state_reg == S_IDLE) && !ovalid_reg;
    assign accept      = s_tvalid && s_tready;
    assign cst_addr_in = {RB'(in_row), CB'(in_col)};

    // ------------------------------------------------------------------
    // Neighbor step: one shared stepper for popped pixel and solved pixel
    // ------------------------------------------------------------------
    logic [RB-1:0] st_r, nb_r;
    logic [CB-1:0] st_c, nb_c;
    logic [1:0]    st_dir;
    logic          nb_ok;

    always_comb
    begin
        if (state_reg == S_NB)
        begin
            st_r   = pr_reg;
            st_c   = pc_reg;
            st_dir = k_reg[1:0];
        end
        else
        begin
            st_r   = qr_reg;
            st_c   = qc_reg;
            st_dir = j_reg;
        end
        nb_r = st_r;
        nb_c = st_c;
        case (st_dir)
            DIR_LEFT:
            begin
                nb_ok = st_c != '0;
                nb_c  = st_c - 1'b1;
            end
            DIR_RIGHT:
            begin
                nb_ok = (DIM_W'(st_c) + DIM_W'(1)) < gw_eff;
                nb_c  = st_c + 1'b1;
            end
            DIR_UP:
            begin
                nb_ok = st_r != '0;
                nb_r  = st_r - 1'b1;
            end
            DIR_DOWN:
            begin
                nb_ok = (DIM_W'(st_r) + DIM_W'(1)) < gh_eff;
                nb_r  = st_r + 1'b1;
            end
            default:
            begin
                nb_ok = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Solver arithmetic
    // ------------------------------------------------------------------
    logic [DIST_BITS-1:0] fld_dist, rd_val, diff, mmin;
    logic                 fld_mark;
    logic [SQ_IN_W-1:0]   prod;
    logic                 diff_small, both_fin;
    logic [DIST_BITS:0]   lin_sum;
    logic [DIST_BITS+1:0] root_sum;
    logic [DIST_BITS:0]   root_half;
    logic [DIST_BITS-1:0] lin_sat, root_sat;
    logic                 sq_start, sq_done;
    logic [SQ_OUT_W-1:0]  sq_root;

    assign fld_dist   = fld_rdata[DIST_BITS-1:0];
    assign fld_mark   = fld_rdata[DIST_BITS];
    assign rd_val     = rd_inv_reg ? INF : fld_dist;
    assign diff       = (dx_reg > dy_reg) ? dx_reg - dy_reg : dy_reg - dx_reg;
    assign mmin       = (dx_reg < dy_reg) ? dx_reg : dy_reg;
    assign diff_small = 33'(diff) < 33'(1 << 17);
    assign both_fin   = (dx_reg != INF) && (dy_reg != INF);
    assign prod       = SQ_IN_W'(ma_reg) * SQ_IN_W'(ma_reg);  // squarer, result registered
    assign lin_sum    = (DIST_BITS+1)'(w_reg) + (DIST_BITS+1)'(mmin);
    assign lin_sat    = (lin_sum > (DIST_BITS+1)'(MAXF)) ? MAXF : lin_sum[DIST_BITS-1:0];
    assign root_sum   = (DIST_BITS+2)'(dx_reg) + (DIST_BITS+2)'(dy_reg)
                      + (DIST_BITS+2)'(sq_root);
    assign root_half  = root_sum[DIST_BITS+1:1];
    assign root_sat   = (root_half > (DIST_BITS+1)'(MAXF)) ? MAXF
                      : root_half[DIST_BITS-1:0];
    assign sq_start   = (state_reg == S_DEC) && both_fin && diff_small
                      && (w2_reg >= d2_reg);

    fmm_sqrt u_sqrt (
        .clk(clk), .rst_n(rst_n), .start(sq_start),
        .radicand(w2_reg - d2_reg), .done(sq_done), .root(sq_root)
    );

    // heap index arithmetic
    logic [HB+1:0] lidx;
    logic [HB-1:0] parent;

    assign lidx   = (HB+2)'({hidx_reg, 1'b1});
    assign parent = (hidx_reg - 1'b1) >> 1;

    // ------------------------------------------------------------------
    // Memory port control
    // ------------------------------------------------------------------
    always_comb
    begin
        fld_we    = 1'b0;
        fld_waddr = {qr_reg, qc_reg};
        fld_wdata = {1'b1, nd_reg};
        fld_raddr = {RB'(in_row), CB'(in_col)};
        cst_we    = accept && (in_func == FN_COST) && in_inside;
        cst_raddr = {qr_reg, qc_reg};
        hp_we     = 1'b0;
        hp_waddr  = hidx_reg;
        hp_wdata  = pkey_reg;
        hp_raddr  = '0;
        case (state_reg)
            S_CLR:
            begin
                fld_we    = 1'b1;
                fld_waddr = clr_cnt_reg;
                fld_wdata = {1'b0, INF};
            end
            S_SEED:
            begin
                fld_we    = !fld_mark;
                fld_waddr = {in_row_reg, in_col_reg};
                fld_wdata = {1'b1, {DIST_BITS{1'b0}}};
            end
            S_UP:
            begin
                hp_we    = hidx_reg == '0;
                hp_raddr = parent;
            end
            S_UP_CMP:
            begin
                hp_we    = 1'b1;
                hp_wdata = (hp_rdata <= pkey_reg) ? pkey_reg : hp_rdata;
            end
            S_POP_TOP:
            begin
                hp_raddr = HB'(heap_cnt_reg - 1'b1);
            end
            S_DN:
            begin
                hp_we    = lidx >= (HB+2)'(heap_cnt_reg);
                hp_wdata = hval_reg;
                hp_raddr = HB'(lidx);
            end
            S_DN_L:
            begin
                hp_raddr = HB'(lidx + 1'b1);
            end
            S_DN_MV:
            begin
                hp_we    = 1'b1;
                hp_wdata = (child_reg < hval_reg) ? child_reg : hval_reg;
            end
            S_NB, S_RD:
            begin
                fld_raddr = {nb_r, nb_c};
            end
            S_STORE:
            begin
                fld_we = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLR;
            clr_cnt_reg  <= '0;
            clr_resp_reg <= 1'b0;
            heap_cnt_reg <= '0;
            ovalid_reg   <= 1'b0;
            gw_reg       <= CFG_W'(64);
            gh_reg       <= CFG_W'(64);
        end
        else
        begin
            if (psel && penable && pwrite)
            begin
                if (paddr == ADDR_GRID_WIDTH)
                    gw_reg <= pwdata[CFG_W-1:0];
                else if (paddr == ADDR_GRID_HEIGHT)
                    gh_reg <= pwdata[CFG_W-1:0];
            end

            if (ovalid_reg && m_tready)
                ovalid_reg <= 1'b0;

            case (state_reg)
                S_CLR:
                begin
                    clr_cnt_reg  <= clr_cnt_reg + 1'b1;
                    heap_cnt_reg <= '0;
                    if (&clr_cnt_reg)
                    begin
                        state_reg <= S_IDLE;
                        if (clr_resp_reg)
                        begin
                            ovalid_reg   <= 1'b1;
                            odist_reg    <= '0;
                            oreached_reg <= 1'b0;
                            odone_reg    <= 1'b1;
                        end
                    end
                end

                S_IDLE:
                begin
                    if (accept)
                    begin
                        in_row_reg   <= RB'(in_row);
                        in_col_reg   <= CB'(in_col);
                        odist_reg    <= '0;
                        oreached_reg <= 1'b0;
                        odone_reg    <= 1'b1;
                        case (in_func)
                            FN_CLEAR:
                            begin
                                clr_cnt_reg  <= '0;
                                clr_resp_reg <= 1'b1;
                                state_reg    <= S_CLR;
                            end
                            FN_COST:
                            begin
                                ovalid_reg <= 1'b1;
                            end
                            FN_SEED:
                            begin
                                if (in_inside)
                                    state_reg <= S_SEED;
                                else
                                    ovalid_reg <= 1'b1;
                            end
                            FN_RUN:
                            begin
                                state_reg <= S_POP;
                            end
                            FN_READ:
                            begin
                                if (in_inside)
                                    state_reg <= S_READ;
                                else
                                begin
                                    ovalid_reg <= 1'b1;
                                    odist_reg  <= INF;
                                end
                            end
                            default:
                            begin
                                ovalid_reg <= 1'b1;
                                odone_reg  <= 1'b0;
                            end
                        endcase
                    end
                end

                S_SEED:
                begin
                    if (fld_mark)
                    begin
                        ovalid_reg <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        pkey_reg     <= {{DIST_BITS{1'b0}}, in_row_reg, in_col_reg};
                        push_run_reg <= 1'b0;
                        state_reg    <= S_PUSH;
                    end
                end

                S_READ:
                begin
                    ovalid_reg   <= 1'b1;
                    odist_reg    <= fld_dist;
                    oreached_reg <= fld_dist != INF;
                    state_reg    <= S_IDLE;
                end

                // insertion: hole climbs from the tail
                S_PUSH:
                begin
                    if (heap_cnt_reg == (HB+1)'(CELLS))
                    begin
                        if (push_run_reg)
                        begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= S_NB;
                        end
                        else
                        begin
                            ovalid_reg <= 1'b1;
                            state_reg  <= S_IDLE;
                        end
                    end
                    else
                    begin
                        hidx_reg     <= HB'(heap_cnt_reg);
                        heap_cnt_reg <= heap_cnt_reg + 1'b1;
                        state_reg    <= S_UP;
                    end
                end

                S_UP:
                begin
                    if (hidx_reg == '0)
                    begin
                        if (push_run_reg)
                        begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= S_NB;
                        end
                        else
                        begin
                            ovalid_reg <= 1'b1;
                            state_reg  <= S_IDLE;
                        end
                    end
                    else
                    begin
                        state_reg <= S_UP_CMP;
                    end
                end

                S_UP_CMP:
                begin
                    if (hp_rdata <= pkey_reg)
                    begin
                        if (push_run_reg)
                        begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= S_NB;
                        end
                        else
                        begin
                            ovalid_reg <= 1'b1;
                            state_reg  <= S_IDLE;
                        end
                    end
                    else
                    begin
                        hidx_reg  <= parent;
                        state_reg <= S_UP;
                    end
                end

                // removal of the minimum: tail entry sifts down from the root
                S_POP:
                begin
                    if (heap_cnt_reg == '0)
                    begin
                        ovalid_reg <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_POP_TOP;
                    end
                end

                S_POP_TOP:
                begin
                    top_reg      <= hp_rdata;
                    heap_cnt_reg <= heap_cnt_reg - 1'b1;
                    state_reg    <= S_POP_LAST;
                end

                S_POP_LAST:
                begin
                    hval_reg <= hp_rdata;
                    hidx_reg <= '0;
                    state_reg <= (heap_cnt_reg == '0) ? S_POP_DONE : S_DN;
                end

                S_DN:
                begin
                    state_reg <= (lidx >= (HB+2)'(heap_cnt_reg)) ? S_POP_DONE : S_DN_L;
                end

                S_DN_L:
                begin
                    child_reg <= hp_rdata;
                    cidx_reg  <= HB'(lidx);
                    state_reg <= ((lidx + 1'b1) < (HB+2)'(heap_cnt_reg)) ? S_DN_R : S_DN_MV;
                end

                S_DN_R:
                begin
                    if (hp_rdata < child_reg)
                    begin
                        child_reg <= hp_rdata;
                        cidx_reg  <= HB'(lidx + 1'b1);
                    end
                    state_reg <= S_DN_MV;
                end

                S_DN_MV:
                begin
                    if (child_reg < hval_reg)
                    begin
                        hidx_reg  <= cidx_reg;
                        state_reg <= S_DN;
                    end
                    else
                    begin
                        state_reg <= S_POP_DONE;
                    end
                end

                // an infinite pop ends the run
                S_POP_DONE:
                begin
                    if (top_reg[KW-1 -: DIST_BITS] == INF)
                    begin
                        ovalid_reg <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        pr_reg    <= top_reg[AB-1:CB];
                        pc_reg    <= top_reg[CB-1:0];
                        k_reg     <= '0;
                        state_reg <= S_NB;
                    end
                end

                S_NB:
                begin
                    if (k_reg[2])
                        state_reg <= S_POP;
                    else if (!nb_ok)
                        k_reg <= k_reg + 1'b1;
                    else
                    begin
                        qr_reg    <= nb_r;
                        qc_reg    <= nb_c;
                        state_reg <= S_NB_CHK;
                    end
                end

                S_NB_CHK:
                begin
                    if (fld_mark)
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_NB;
                    end
                    else
                    begin
                        j_reg     <= '0;
                        dx_reg    <= INF;
                        dy_reg    <= INF;
                        state_reg <= S_RD;
                    end
                end

                // gather row and column minima around the pixel
                S_RD:
                begin
                    rd_inv_reg <= !nb_ok;
                    state_reg  <= S_RD_USE;
                end

                S_RD_USE:
                begin
                    if (!j_reg[1])
                    begin
                        if (rd_val < dx_reg)
                            dx_reg <= rd_val;
                    end
                    else if (rd_val < dy_reg)
                        dy_reg <= rd_val;
                    j_reg     <= j_reg + 1'b1;
                    state_reg <= (j_reg == DIR_DOWN) ? S_COST : S_RD;
                end

                S_COST:
                begin
                    state_reg <= S_SOLVE;
                end

                S_SOLVE:
                begin
                    w_reg  <= cst_rdata;
                    ma_reg <= MUL_W'(cst_rdata);
                    if (dx_reg == INF && dy_reg == INF)
                    begin
                        nd_reg    <= INF;
                        state_reg <= S_STORE;
                    end
                    else
                        state_reg <= S_MUL_W;
                end

                S_MUL_W:
                begin
                    w2_reg    <= {prod[SQ_IN_W-2:0], 1'b0};
                    ma_reg    <= MUL_W'(diff);
                    state_reg <= S_MUL_D;
                end

                S_MUL_D:
                begin
                    d2_reg    <= prod;
                    state_reg <= S_DEC;
                end

                S_DEC:
                begin
                    if (sq_start)
                        state_reg <= S_SQ;
                    else
                    begin
                        nd_reg    <= lin_sat;
                        state_reg <= S_STORE;
                    end
                end

                S_SQ:
                begin
                    if (sq_done)
                    begin
                        nd_reg    <= root_sat;
                        state_reg <= S_STORE;
                    end
                end

                S_STORE:
                begin
                    pkey_reg     <= {nd_reg, qr_reg, qc_reg};
                    push_run_reg <= 1'b1;
                    state_reg    <= S_PUSH;
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = OW'({odone_reg, oreached_reg, odist_reg});
    assign pready   = 1'b1;

    always_comb
    begin
        case (paddr)
            ADDR_GRID_WIDTH:  prdata = 32'(gw_reg);
            ADDR_GRID_HEIGHT: prdata = 32'(gh_reg);
            default:          prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// ===== test/tb_grid_fast_marching_distance.sv =====
// ----------------------------------------------------------------------------
// tb_grid_fast_marching_distance
// Self-checking bench for the grid fast marching block. Words are queued by a
// phase generator, which also predicts every result; a bursty driver feeds the
// stream port, and a monitor with its own stall pattern checks each result.
// ----------------------------------------------------------------------------
module tb_grid_fast_marching_distance;
    import fmm_pkg::*;

    localparam int ROWS      = 64;
    localparam int COLS      = 64;
    localparam int CELLS     = ROWS * COLS;
    localparam logic [23:0] DIST_INF  = 24'hFFFFFF;
    localparam logic [23:0] DIST_MAXF = 24'hFFFFFE;
    localparam int IDLE_LIMIT = 200000;  // cycles with no word moving

    typedef struct packed {
        logic [2:0]  func;
        logic [5:0]  row;
        logic [5:0]  col;
        logic [15:0] cost;
    } fmm_word_t;

    typedef struct packed {
        logic [23:0] distance;
        logic        reached;
        logic        done_flag;
    } fmm_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // row[5:0], col[11:6], cost[27:12]
    logic [2:0]  s_tuser = '0;   // func[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // distance[23:0], reached[24], done_res[25]
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    grid_fast_marching_distance u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow of the solver state
    // ------------------------------------------------------------------
    logic [15:0] cost_mem [CELLS];
    bit          cost_known [CELLS];
    logic [23:0] dist_mem [CELLS];
    bit          mark_mem [CELLS];
    logic [63:0] heap_mem [CELLS];
    int          heap_n;
    logic [6:0]  cfg_width;
    logic [6:0]  cfg_height;

    fmm_word_t   pending_q[$];
    fmm_result_t result_q[$];
    int          err_count = 0;
    int          word_count = 0;

    function automatic int span(logic [6:0] v);
        if (v == 0) return 1;
        if (v > ROWS) return ROWS;
        return int'(v);
    endfunction

    function automatic logic [63:0] dist_near(int r, int c);
        if (r < 0 || c < 0 || r >= span(cfg_height) || c >= span(cfg_width))
            return {40'd0, DIST_INF};
        return {40'd0, dist_mem[r * COLS + c]};
    endfunction

    function automatic logic [63:0] root_floor(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] probe;
        res = 0;
        probe = 64'h1 << 62;
        while (probe > v) probe = probe >> 2;
        while (probe != 0)
        begin
            if (v >= res + probe)
            begin
                v = v - (res + probe);
                res = (res >> 1) + probe;
            end
            else
                res = res >> 1;
            probe = probe >> 2;
        end
        return res;
    endfunction

    function automatic void heap_insert(logic [63:0] key);
        int i;
        int p;
        logic [63:0] t;
        if (heap_n >= CELLS) return;
        i = heap_n;
        heap_n++;
        heap_mem[i] = key;
        while (i > 0)
        begin
            p = (i - 1) / 2;
            if (heap_mem[p] <= heap_mem[i]) break;
            t = heap_mem[p]; heap_mem[p] = heap_mem[i]; heap_mem[i] = t;
            i = p;
        end
    endfunction

    function automatic logic [63:0] heap_take();
        logic [63:0] top;
        logic [63:0] t;
        int i;
        int l;
        int m;
        top = heap_mem[0];
        i = 0;
        heap_n--;
        heap_mem[0] = heap_mem[heap_n];
        forever
        begin
            l = 2 * i + 1;
            m = i;
            if (l < heap_n && heap_mem[l] < heap_mem[m]) m = l;
            if (l + 1 < heap_n && heap_mem[l + 1] < heap_mem[m]) m = l + 1;
            if (m == i) break;
            t = heap_mem[m]; heap_mem[m] = heap_mem[i]; heap_mem[i] = t;
            i = m;
        end
        return top;
    endfunction

    // Eikonal update: one-sided w+min, or the two-sided root when it exists
    function automatic logic [63:0] arrival(int r, int c);
        logic [63:0] a, b, dx, dy, w, val, diff;
        a = dist_near(r, c - 1);
        b = dist_near(r, c + 1);
        dx = a < b ? a : b;
        a = dist_near(r - 1, c);
        b = dist_near(r + 1, c);
        dy = a < b ? a : b;
        if (dx == DIST_INF && dy == DIST_INF) return {40'd0, DIST_INF};
        w = {48'd0, cost_mem[r * COLS + c]};
        val = w + (dx < dy ? dx : dy);
        if (dx != DIST_INF && dy != DIST_INF)
        begin
            diff = dx > dy ? dx - dy : dy - dx;
            if (diff < (64'h1 << 17) && 2 * w * w >= diff * diff)
                val = (dx + dy + root_floor(2 * w * w - diff * diff)) >> 1;
        end
        if (val > DIST_MAXF) val = {40'd0, DIST_MAXF};
        return val;
    endfunction

    function automatic void march();
        logic [63:0] key;
        logic [63:0] nd;
        int pr, pc, qr, qc, k, idx;
        int gh;
        int gw;
        gh = span(cfg_height);
        gw = span(cfg_width);
        while (heap_n > 0)
        begin
            key = heap_take();
            if ((key >> 20) >= DIST_INF) break;
            pr = int'((key >> 10) & 1023);
            pc = int'(key & 1023);
            // left, right, up, down
            for (k = 0; k < 4; k++)
            begin
                qr = pr + (k == 2 ? -1 : (k == 3 ? 1 : 0));
                qc = pc + (k == 0 ? -1 : (k == 1 ? 1 : 0));
                if (qr < 0 || qc < 0 || qr >= gh || qc >= gw) continue;
                idx = qr * COLS + qc;
                if (mark_mem[idx]) continue;
                nd = arrival(qr, qc);
                dist_mem[idx] = nd[23:0];
                mark_mem[idx] = 1'b1;
                heap_insert((nd << 20) | (64'(qr) << 10) | 64'(qc));
            end
        end
    endfunction

    function automatic void wipe_field();
        for (int i = 0; i < CELLS; i++)
        begin
            dist_mem[i] = DIST_INF;
            mark_mem[i] = 1'b0;
        end
        heap_n = 0;
    endfunction

    // Queue one word and record the result it must produce
    function automatic void send_word(logic [2:0] func, int r, int c, logic [15:0] cost);
        fmm_word_t   wd;
        fmm_result_t res;
        bit          in_grid;
        int          idx;
        wd.func = func;
        wd.row  = r[5:0];
        wd.col  = c[5:0];
        wd.cost = cost;
        in_grid = wd.row < span(cfg_height) && wd.col < span(cfg_width);
        idx = int'(wd.row) * COLS + int'(wd.col);
        res = '{distance: '0, reached: 1'b0, done_flag: 1'b1};
        case (func)
            FN_CLEAR: wipe_field();
            FN_COST:
                if (in_grid)
                begin
                    cost_mem[idx] = cost;
                    cost_known[idx] = 1'b1;
                end
            FN_SEED:
                if (in_grid && !mark_mem[idx])
                begin
                    dist_mem[idx] = '0;
                    mark_mem[idx] = 1'b1;
                    heap_insert((64'(wd.row) << 10) | 64'(wd.col));
                end
            FN_RUN: march();
            FN_READ:
            begin
                res.distance = in_grid ? dist_mem[idx] : DIST_INF;
                res.reached  = res.distance != DIST_INF;
            end
            default: res.done_flag = 1'b0;
        endcase
        pending_q.push_back(wd);
        result_q.push_back(res);
        word_count++;
    endfunction

    // ------------------------------------------------------------------
    // Stream driver: bursts of random length with random gaps
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk)
    begin
        if (rst_n && !(s_tvalid && !s_tready))
        begin
            if (s_tvalid && s_tready) void'(pending_q.pop_front());
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (pending_q.size() > 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= {4'd0, pending_q[0].cost, pending_q[0].col, pending_q[0].row};
                s_tuser  <= pending_q[0].func;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left--;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor with a stall pattern that changes mode every so often
    // ------------------------------------------------------------------
    int stall_mode = 0;
    int stall_timer = 0;
    fmm_result_t got_res;
    fmm_result_t want_res;

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %0h want %0h (word %0d left %0d)",
                 what, got, want, word_count, result_q.size());
        err_count++;
    endtask

    always @(posedge clk)
    begin
        if (stall_timer == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_timer = $urandom_range(50, 400);
        end
        else
            stall_timer--;
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= $urandom_range(0, 9) < 7;
            default: m_tready <= $urandom_range(0, 9) < 3;
        endcase
        if (rst_n && m_tvalid && m_tready)
        begin
            got_res = '{distance: m_tdata[23:0], reached: m_tdata[24], done_flag: m_tdata[25]};
            if (result_q.size() == 0)
                report_mismatch("unexpected word", m_tdata, 32'd0);
            else
            begin
                want_res = result_q.pop_front();
                if (got_res.distance !== want_res.distance)
                    report_mismatch("distance", got_res.distance, want_res.distance);
                if (got_res.reached !== want_res.reached)
                    report_mismatch("reached", got_res.reached, want_res.reached);
                if (got_res.done_flag !== want_res.done_flag)
                    report_mismatch("done_res", got_res.done_flag, want_res.done_flag);
            end
        end
    end

    // Watchdog: covers the clearing sweep after reset and the longest run
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic reg_write(logic [2:0] addr, logic [6:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {25'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic drain();
        while (pending_q.size() > 0 || result_q.size() > 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_cost(int mode);
        case (mode)
            0: return 16'($urandom());
            1: return 16'($urandom_range(0, 16'h0300));
            2: return 16'hFFFF;
            default:
                case ($urandom_range(0, 2))
                    0: return 16'h0000;
                    1: return 16'hFFFF;
                    default: return 16'($urandom());
                endcase
        endcase
    endfunction

    // Grid change only while idle; every in-grid cost is loaded before a run
    task automatic set_grid(logic [6:0] w, logic [6:0] h, int cost_mode);
        drain();
        reg_write(ADDR_GRID_WIDTH, w);
        reg_write(ADDR_GRID_HEIGHT, h);
        cfg_width = w;
        cfg_height = h;
        for (int r = 0; r < span(h); r++)
            for (int c = 0; c < span(w); c++)
                if (!cost_known[r * COLS + c] || $urandom_range(0, 7) == 0)
                    send_word(FN_COST, r, c, pick_cost(cost_mode));
    endtask

    task automatic random_phase(logic [6:0] w, logic [6:0] h, int cost_mode);
        int gh;
        int gw;
        int pick;
        set_grid(w, h, cost_mode);
        gh = span(h);
        gw = span(w);
        if ($urandom_range(0, 3) != 0) send_word(FN_CLEAR, 0, 0, 16'($urandom()));
        repeat ($urandom_range(1, 3))
            send_word(FN_SEED, $urandom_range(0, gh - 1), $urandom_range(0, gw - 1),
                      16'($urandom()));
        send_word(FN_RUN, $urandom_range(0, 63), $urandom_range(0, 63), 16'($urandom()));
        repeat ($urandom_range(4, 12))
            send_word(FN_READ, $urandom_range(0, gh - 1), $urandom_range(0, gw - 1), '0);
        repeat ($urandom_range(4, 14))
        begin
            pick = $urandom_range(0, 19);
            if (pick < 8)
                send_word(FN_READ, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                          : $urandom_range(0, gh - 1), $urandom_range(0, 63) % (gw + 1),
                          16'($urandom()));
            else if (pick < 12)
                send_word(FN_SEED, $urandom_range(0, 63) % (gh + 1),
                          $urandom_range(0, 63) % (gw + 1), 16'($urandom()));
            else if (pick < 15)
                send_word(FN_RUN, 0, 0, '0);
            else if (pick < 17)
                send_word(FN_COST, $urandom_range(0, 63) % (gh + 1),
                          $urandom_range(0, 63) % (gw + 1), pick_cost(cost_mode));
            else if (pick < 18)
                send_word(FN_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63), '0);
            else
                send_word(3'($urandom_range(5, 7)), $urandom_range(0, 63),
                          $urandom_range(0, 63), 16'($urandom()));
        end
        send_word(FN_RUN, 0, 0, '0);
        repeat ($urandom_range(2, 6))
            send_word(FN_READ, $urandom_range(0, gh - 1), $urandom_range(0, gw - 1), '0);
    endtask

    initial
    begin
        logic [6:0] w;
        logic [6:0] h;
        for (int i = 0; i < CELLS; i++)
        begin
            cost_mem[i] = '0;
            cost_known[i] = 1'b0;
        end
        wipe_field();
        cfg_width = 7'd64;
        cfg_height = 7'd64;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: 4x3 grid with extreme costs, duplicate and outside seeds,
        // reads inside and outside, two unknown codes and a clear
        set_grid(7'd4, 7'd3, 3);
        send_word(FN_COST, 0, 0, 16'h0000);
        send_word(FN_COST, 2, 3, 16'hFFFF);
        send_word(FN_COST, 63, 63, 16'h1234);
        send_word(FN_SEED, 0, 0, '0);
        send_word(FN_SEED, 0, 0, '0);
        send_word(FN_SEED, 1, 63, '0);
        send_word(FN_RUN, 0, 0, '0);
        send_word(FN_READ, 0, 0, '0);
        send_word(FN_READ, 1, 1, '0);
        send_word(FN_READ, 2, 3, '0);
        send_word(FN_READ, 63, 0, '0);
        send_word(3'd7, 63, 63, 16'hFFFF);
        send_word(3'd5, 0, 0, '0);
        send_word(FN_CLEAR, 0, 0, '0);
        send_word(FN_READ, 2, 3, '0);
        send_word(FN_RUN, 0, 0, '0);

        // Register extremes of the grid extents
        random_phase(7'd64, 7'd5, 2);
        random_phase(7'd1, 7'd64, 0);
        random_phase(7'd127, 7'd2, 3);
        random_phase(7'd0, 7'd0, 1);
        random_phase(7'd2, 7'd127, 1);

        while (word_count < 650)
        begin
            w = 7'($urandom_range(1, 8));
            h = 7'($urandom_range(1, 8));
            if ($urandom_range(0, 9) == 0) w = 7'($urandom_range(0, 127));
            if ($urandom_range(0, 9) == 0) h = 7'($urandom_range(0, 4));
            random_phase(w, h, $urandom_range(0, 3));
        end

        drain();
        repeat (50) @(posedge clk);
        if (err_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
